>>> design/bir_pkg.sv
// Shared types, field widths and tap weights of the B-spline reconstruction block.
// No dependencies; every other design file imports this package.
package bir_pkg;

	localparam int COORD_W = 9;
	localparam int COEF_W  = 24;
	localparam int PIXEL_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Tap weights are in units of 1/32; a pair of them fits in 11 bits.
	localparam int WT_W     = 6;
	localparam int WT2_W    = 12;
	localparam int PROD_W   = COEF_W + WT2_W;
	localparam int ACC_W    = PROD_W + 4;
	localparam int FRAC_SHIFT = 18;

	localparam logic [WT_W-1:0] W_QUARTER = 6'd8;
	localparam logic [WT_W-1:0] W_ONE     = 6'd32;
	localparam logic [WT_W-1:0] W_NEAR    = 6'd23;
	localparam logic [WT_W-1:0] W_FAR     = 6'd1;
	localparam logic [WT_W-1:0] W_NONE    = 6'd0;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = 40'sd131072;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH    = 2'd0,
		REG_GRID_HEIGHT   = 2'd1,
		REG_UPSAMPLE_MODE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} item_kind_t;

	// Weight of tap k on one axis: odd positions of 2x mode use four taps,
	// all other positions use three with the fourth absent.
	function automatic logic [WT_W-1:0] tap_weight(input logic odd, input logic [1:0] k);
		logic [WT_W-1:0] w;
		w = W_NONE;
		if (odd) begin
			case (k)
				2'd0: w = W_FAR;
				2'd1: w = W_NEAR;
				2'd2: w = W_NEAR;
				default: w = W_FAR;
			endcase
		end else begin
			case (k)
				2'd0: w = W_QUARTER;
				2'd1: w = W_ONE;
				2'd2: w = W_QUARTER;
				default: w = W_NONE;
			endcase
		end
		return w;
	endfunction

endpackage

>>> design/bir_if.sv
// Valid/ready channel interfaces for the request words and the pixel words.
// Depends on bir_pkg for the field widths.
interface bir_item_if import bir_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [COORD_W-1:0]        column;
	logic [COORD_W-1:0]        row;
	logic signed [COEF_W-1:0]  coefficient;

	modport source (output valid, kind, column, row, coefficient, input ready);
	modport sink   (input valid, kind, column, row, coefficient, output ready);
endinterface

interface bir_result_if import bir_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, pixel, input ready);
	modport sink   (input valid, pixel, output ready);
endinterface

>>> design/bspline_image_reconstruct.sv
// Cubic B-spline image reconstruction at 1x or 2x resolution.
// Depends on bir_pkg and on the channel interfaces in bir_if.sv.
//
// Usage: words enter on the item channel. A write word (kind 0) stores one
// signed Q16.8 coefficient at (row, column) in an on-chip grid memory of
// MAX_GRID_SIDE x MAX_GRID_SIDE entries; it gives no result. A read word (kind 1)
// gives one 8-bit pixel on the result channel. A read steps through a 4 x 4 tap
// window, one memory read per cycle through a single multiply-accumulate path,
// then drains two pipeline stages and rounds; the next word is accepted only
// once the pixel has gone into the output register.
// A read outside the image skips the tap window and is answered with 0, and the
// next word is accepted once that answer has gone into the output register.
// The result sits in an output register; the block takes the next word while
// that register waits. If the receiver stalls with a pixel still held, a
// following read holds in its final step until the register frees.
// Configuration (grid_width, grid_height, upsample_mode) is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while the block is idle, as the block does not enforce this.
// Reset clears the sequencer and the registers to width 256, height 256 and
// 1x mode. The grid memory is not cleared; write coefficients before reading.
module bspline_image_reconstruct import bir_pkg::*; #(
	parameter int MAX_GRID_SIDE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bir_item_if.sink              item,
	bir_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SW    = $clog2(MAX_GRID_SIDE);
	localparam int CW    = (SW + 1 > COORD_W + 1) ? SW + 1 : COORD_W + 1;
	localparam int OW    = CW + 1;
	localparam int IW    = CW + 1;
	localparam int ADR_W = 2 * SW;
	localparam int DEPTH = 1 << ADR_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_TAP   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0] grid_width_q;
	logic [CFG_DATA_W-1:0] grid_height_q;
	logic                  mode_q;

	logic [COORD_W-1:0] base_x_q, base_y_q;
	logic               odd_x_q, odd_y_q;
	logic [3:0]         tap_q;

	logic [COEF_W-1:0]        mem [DEPTH];
	logic signed [COEF_W-1:0] rd_data_s1;
	logic                     vld_s1;
	logic [WT2_W-1:0]         wt_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic               res_valid_q;
	logic [PIXEL_W-1:0] res_pixel_q;

	// Effective grid sizes and output image sizes.
	logic [CW-1:0] nw, nh, col_ext, row_ext;
	logic [OW-1:0] out_w, out_h;
	logic          accept, outside, in_storage;

	always_comb begin
		nw = (CW'(grid_width_q) > CW'(MAX_GRID_SIDE)) ? CW'(MAX_GRID_SIDE) : CW'(grid_width_q);
		nh = (CW'(grid_height_q) > CW'(MAX_GRID_SIDE)) ? CW'(MAX_GRID_SIDE) : CW'(grid_height_q);
		if (!mode_q) begin
			out_w = OW'(nw);
			out_h = OW'(nh);
		end else begin
			out_w = (nw == '0) ? '0 : (OW'(nw) << 1) - OW'(1);
			out_h = (nh == '0) ? '0 : (OW'(nh) << 1) - OW'(1);
		end
		col_ext    = CW'(item.column);
		row_ext    = CW'(item.row);
		outside    = (OW'(item.column) >= out_w) || (OW'(item.row) >= out_h);
		in_storage = (col_ext < CW'(MAX_GRID_SIDE)) && (row_ext < CW'(MAX_GRID_SIDE));
	end

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	// Current tap of the 4 x 4 window: tap_q[1:0] runs along x, tap_q[3:2] along y.
	logic signed [IW-1:0] xi, yi;
	logic [WT_W-1:0]      wx, wy;
	logic                 tap_vld;
	logic [ADR_W-1:0]     rd_addr;

	always_comb begin
		xi = $signed(IW'(base_x_q)) + $signed(IW'(tap_q[1:0])) - $signed(IW'(1));
		yi = $signed(IW'(base_y_q)) + $signed(IW'(tap_q[3:2])) - $signed(IW'(1));
		wx = tap_weight(odd_x_q, tap_q[1:0]);
		wy = tap_weight(odd_y_q, tap_q[3:2]);
		tap_vld = (wx != W_NONE) && (wy != W_NONE)
			&& !xi[IW-1] && (xi[CW-1:0] < nw)
			&& !yi[IW-1] && (yi[CW-1:0] < nh);
		rd_addr = {yi[SW-1:0], xi[SW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_WRITE && in_storage) begin
			mem[{row_ext[SW-1:0], col_ext[SW-1:0]}] <= item.coefficient;
		end
		if (state_q == S_TAP && tap_vld) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		wt_s1   <= WT2_W'(wx) * WT2_W'(wy);
		prod_s2 <= rd_data_s1 * $signed({1'b0, wt_s1[WT2_W-2:0]});
	end

	// Rounding half up and clamping of the finished sum.
	logic signed [ACC_W-1:0] rounded;
	logic [PIXEL_W-1:0]      pixel_d;

	always_comb begin
		rounded = acc_q + ROUND_HALF;
		if (acc_q <= 0) begin
			pixel_d = '0;
		end else if (|rounded[ACC_W-1:FRAC_SHIFT+PIXEL_W]) begin
			pixel_d = '1;
		end else begin
			pixel_d = rounded[FRAC_SHIFT+PIXEL_W-1:FRAC_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			grid_width_q  <= CFG_DATA_W'(256);
			grid_height_q <= CFG_DATA_W'(256);
			mode_q        <= 1'b0;
			tap_q         <= '0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:    grid_width_q  <= cfg_data;
					REG_GRID_HEIGHT:   grid_height_q <= cfg_data;
					REG_UPSAMPLE_MODE: mode_q        <= cfg_data[0];
					default: ;
				endcase
			end

			vld_s1 <= (state_q == S_TAP) && tap_vld;
			vld_s2 <= vld_s1;

			if (state_q == S_DONE && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && item.kind == KIND_READ) begin
						tap_q   <= '0;
						state_q <= outside ? S_DONE : S_TAP;
					end
				end
				S_TAP: begin
					tap_q <= tap_q + 4'd1;
					if (tap_q == 4'd15) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// The drain lets the last tap pass the multiply and the add.
					tap_q <= tap_q + 4'd1;
					if (tap_q[0]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_READ) begin
			base_x_q <= mode_q ? (item.column >> 1) : item.column;
			base_y_q <= mode_q ? (item.row >> 1) : item.row;
			odd_x_q  <= mode_q & item.column[0];
			odd_y_q  <= mode_q & item.row[0];
		end
		if (accept) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == S_DONE && (!res_valid_q || result.ready)) begin
			res_pixel_q <= pixel_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.pixel = res_pixel_q;

endmodule

>>> design/bir_checker.sv
// Port-level checks on the B-spline reconstruction block, bound to its top level.
// Depends on bir_pkg for field widths and word kinds.
module bir_checker import bir_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               item_kind,
	input logic               result_valid,
	input logic               result_ready,
	input logic [PIXEL_W-1:0] result_pixel
);

	// A held pixel word stays until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_pixel))
		else $error("result word changed or dropped while stalled");

	// A write word never produces a pixel.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_kind == KIND_WRITE && !result_valid
		|=> !result_valid)
		else $error("pixel word appeared after a coefficient write");

	// A read occupies the sequencer, so the item channel drops ready after it is taken.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_kind == KIND_READ |=> !item_ready)
		else $error("item channel ready right after a read was accepted");

	// A pixel never appears in the cycle right after its read is taken.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_kind == KIND_READ && !result_valid
		|=> !result_valid)
		else $error("pixel word appeared too early after a read");

endmodule

bind bspline_image_reconstruct bir_checker u_bir_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_kind    (item.kind),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_pixel (result.pixel)
);

>>> dv/testbench.sv
// Testbench for bspline_image_reconstruct: coefficient writes and pixel reads
// are checked against a predictor of the 1x and 2x reconstruction.
// Depends on bir_pkg, the channel interfaces in bir_if.sv and the block itself.
`timescale 1ns / 100ps

module testbench;
	import bir_pkg::*;

	localparam int SIDE = 256;
	localparam int TAP_QUARTER = 8;
	localparam int TAP_UNIT = 32;
	localparam int TAP_NEAR = 23;
	localparam int TAP_FAR = 1;
	localparam longint ROUND_BIAS = 64'd131072;
	localparam int FRAC_BITS = 18;
	localparam int DRAIN_CYCLES = 30;
	localparam int OPENING_ROWS = 25;
	localparam int PLANNED = 9;
	localparam int PHASES = 15;
	localparam int PHASE_WORDS = 118;
	localparam int PLAN_W [PLANNED] = '{256, 2, 256, 511, 0, 4, 1, 1, 3};
	localparam int PLAN_H [PLANNED] = '{256, 2, 256, 300, 5, 0, 1, 3, 7};
	localparam int PLAN_UP [PLANNED] = '{0, 1, 1, 1, 0, 1, 1, 0, 1};

	typedef struct packed {
		item_kind_t         kind;
		logic [8:0]         column;
		logic [8:0]         row;
		logic [COEF_W-1:0]  coefficient;
		logic               pinned;
		logic [PIXEL_W-1:0] pixel;
	} probe_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bir_item_if   item_ch ();
	bir_result_if pixel_ch ();

	bspline_image_reconstruct #(.MAX_GRID_SIDE(SIDE)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (pixel_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the coefficient memory and of the configuration registers.
	logic signed [COEF_W-1:0] grid_coef [SIDE*SIDE];
	bit                       coef_known [SIDE*SIDE];
	int                       width_reg = 256;
	int                       height_reg = 256;
	bit                       mode_2x = 1'b0;

	logic [PIXEL_W-1:0] pixel_due [$];
	int                 mismatch_count = 0;
	int                 words_sent = 0;
	int                 idle_pct = 15;
	int                 stall_pct = 20;

	// Starts at 256x256 in 1x mode, as after reset.
	probe_t opening [OPENING_ROWS] = '{
		'{KIND_WRITE, 9'd0,   9'd0,   24'd25600,    1'b0, 8'd0},
		'{KIND_WRITE, 9'd1,   9'd0,   24'd0,        1'b0, 8'd0},
		'{KIND_WRITE, 9'd0,   9'd1,   24'd0,        1'b0, 8'd0},
		'{KIND_WRITE, 9'd1,   9'd1,   24'd0,        1'b0, 8'd0},
		'{KIND_READ,  9'd0,   9'd0,   24'd0,        1'b1, 8'd100},
		'{KIND_WRITE, 9'd1,   9'd0,   24'd12345,    1'b0, 8'd0},
		'{KIND_READ,  9'd0,   9'd0,   24'hFFFFFF,   1'b0, 8'd0},
		'{KIND_WRITE, 9'd0,   9'd0,   24'h7FFFFF,   1'b0, 8'd0},
		'{KIND_READ,  9'd0,   9'd0,   24'd0,        1'b1, 8'd255},
		'{KIND_WRITE, 9'd0,   9'd0,   24'h800000,   1'b0, 8'd0},
		'{KIND_READ,  9'd0,   9'd0,   24'd0,        1'b1, 8'd0},
		'{KIND_WRITE, 9'd256, 9'd0,   24'h7FFFFF,   1'b0, 8'd0},
		'{KIND_WRITE, 9'd0,   9'd511, 24'h7FFFFF,   1'b0, 8'd0},
		'{KIND_READ,  9'd0,   9'd0,   24'd0,        1'b1, 8'd0},
		'{KIND_WRITE, 9'd0,   9'd0,   24'd128,      1'b0, 8'd0},
		'{KIND_WRITE, 9'd1,   9'd0,   24'd0,        1'b0, 8'd0},
		'{KIND_READ,  9'd0,   9'd0,   24'd0,        1'b1, 8'd1},
		'{KIND_WRITE, 9'd255, 9'd255, 24'd51200,    1'b0, 8'd0},
		'{KIND_WRITE, 9'd254, 9'd255, 24'd0,        1'b0, 8'd0},
		'{KIND_WRITE, 9'd255, 9'd254, 24'd0,        1'b0, 8'd0},
		'{KIND_WRITE, 9'd254, 9'd254, 24'd0,        1'b0, 8'd0},
		'{KIND_READ,  9'd255, 9'd255, 24'd0,        1'b1, 8'd200},
		'{KIND_READ,  9'd256, 9'd0,   24'd0,        1'b1, 8'd0},
		'{KIND_READ,  9'd0,   9'd256, 24'd0,        1'b1, 8'd0},
		'{KIND_READ,  9'd511, 9'd511, 24'hFFFFFF,   1'b1, 8'd0}
	};

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clip_side(input int n);
		return (n > SIDE) ? SIDE : n;
	endfunction

	function automatic int image_side(input int n);
		if (!mode_2x) begin
			return n;
		end
		return (n == 0) ? 0 : 2 * n - 1;
	endfunction

	// First coefficient, tap count and weights (in 1/32) along one axis.
	function automatic void axis_window(input int pos, output int first, output int count,
			output int wt [4]);
		if (!mode_2x || pos % 2 == 0) begin
			first = (mode_2x ? pos / 2 : pos) - 1;
			count = 3;
			wt = '{TAP_QUARTER, TAP_UNIT, TAP_QUARTER, 0};
		end else begin
			first = pos / 2 - 1;
			count = 4;
			wt = '{TAP_FAR, TAP_NEAR, TAP_NEAR, TAP_FAR};
		end
	endfunction

	function automatic logic [PIXEL_W-1:0] predict_pixel(input int col, input int row);
		int     nw, nh, x0, y0, xn, yn, a, b, x, y;
		int     xw [4];
		int     yw [4];
		longint acc;
		nw = clip_side(width_reg);
		nh = clip_side(height_reg);
		acc = 0;
		if (col >= image_side(nw) || row >= image_side(nh)) begin
			return '0;
		end
		axis_window(col, x0, xn, xw);
		axis_window(row, y0, yn, yw);
		for (b = 0; b < yn; b++) begin
			y = y0 + b;
			if (y < 0 || y >= nh) continue;
			for (a = 0; a < xn; a++) begin
				x = x0 + a;
				if (x < 0 || x >= nw) continue;
				acc += longint'(grid_coef[y*SIDE+x]) * longint'(xw[a] * yw[b]);
			end
		end
		if (acc <= 0) begin
			return '0;
		end
		acc = (acc + ROUND_BIAS) >>> FRAC_BITS;
		return (acc > 255) ? 8'd255 : acc[7:0];
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		int pick, v;
		pick = $urandom_range(99);
		if (pick < 60) begin
			v = int'($urandom_range(0, 72000)) - 2000;
		end else if (pick < 80) begin
			v = int'($urandom_range(0, 4000)) - 2000;
		end else begin
			v = $urandom;
		end
		return v[COEF_W-1:0];
	endfunction

	function automatic int pick_coord(input int n);
		int pick;
		pick = $urandom_range(3);
		if (pick == 0) begin
			return 0;
		end else if (pick == 1) begin
			return n - 1;
		end
		return $urandom_range(0, n - 1);
	endfunction

	function automatic int pick_side();
		int pick;
		pick = $urandom_range(9);
		if (pick < 8) begin
			return $urandom_range(2, 12);
		end else if (pick == 8) begin
			return $urandom_range(13, 256);
		end
		return $urandom_range(257, 511);
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// One word on the item channel; returns at the edge where it is taken.
	task automatic send_word(input item_kind_t k, input int col, input int row,
			input logic [COEF_W-1:0] coef, input logic pinned,
			input logic [PIXEL_W-1:0] pinned_pixel);
		int gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.column <= col[8:0];
		item_ch.row <= row[8:0];
		item_ch.coefficient <= coef;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		words_sent++;
		if (k == KIND_WRITE) begin
			if (col < SIDE && row < SIDE) begin
				grid_coef[row*SIDE+col] = coef;
				coef_known[row*SIDE+col] = 1'b1;
			end
		end else begin
			pixel_due.push_back(pinned ? pinned_pixel : predict_pixel(col, row));
		end
	endtask

	// Writes every coefficient that a read at (col, row) touches and that
	// has not been written yet, so no read ever sees undefined memory.
	task automatic prime_window(input int col, input int row);
		int nw, nh, x0, y0, xn, yn, a, b, x, y;
		int xw [4];
		int yw [4];
		nw = clip_side(width_reg);
		nh = clip_side(height_reg);
		if (col >= image_side(nw) || row >= image_side(nh)) begin
			return;
		end
		axis_window(col, x0, xn, xw);
		axis_window(row, y0, yn, yw);
		for (b = 0; b < yn; b++) begin
			for (a = 0; a < xn; a++) begin
				x = x0 + a;
				y = y0 + b;
				if (x >= 0 && x < nw && y >= 0 && y < nh && !coef_known[y*SIDE+x]) begin
					send_word(KIND_WRITE, x, y, random_coef(), 1'b0, '0);
				end
			end
		end
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pixel_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// All three registers back to back, with the write enable held high.
	task automatic configure(input int w, input int h, input bit up);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= w[8:0];
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data <= h[8:0];
		@(posedge clk);
		cfg_index <= REG_UPSAMPLE_MODE;
		cfg_data <= {8'($urandom), up};
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w & 511;
		height_reg = h & 511;
		mode_2x = up;
	endtask

	initial begin
		int  hold;
		hold = 0;
		pixel_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				pixel_ch.ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				hold = $urandom_range(1, 19) - 1;
				pixel_ch.ready <= 1'b0;
			end else begin
				pixel_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1) begin
			if (pixel_due.size() == 0) begin
				note_mismatch("pixel word with none pending", -1, pixel_ch.pixel);
			end else if (pixel_ch.pixel !== pixel_due[0]) begin
				note_mismatch("pixel mismatch", pixel_due.pop_front(), pixel_ch.pixel);
			end else begin
				void'(pixel_due.pop_front());
			end
		end
	end

	initial begin
		int nw, nh, ow, oh, goal, pick, col, row, w, h, i, phase;
		bit up;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.kind <= KIND_WRITE;
		item_ch.column <= '0;
		item_ch.row <= '0;
		item_ch.coefficient <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < OPENING_ROWS; i++) begin
			send_word(opening[i].kind, opening[i].column, opening[i].row,
				opening[i].coefficient, opening[i].pinned, opening[i].pixel);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase < PLANNED) begin
				w = PLAN_W[phase];
				h = PLAN_H[phase];
				up = PLAN_UP[phase];
			end else begin
				w = pick_side();
				h = pick_side();
				up = $urandom_range(1);
			end
			// The closing phase runs with both sides always ready.
			if (phase == PHASES - 1) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = 15 * $urandom_range(2);
				stall_pct = 15 * $urandom_range(2);
			end
			configure(w, h, up);
			nw = clip_side(width_reg);
			nh = clip_side(height_reg);
			ow = image_side(nw);
			oh = image_side(nh);
			goal = words_sent + PHASE_WORDS;
			while (words_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 50 && ow > 0 && oh > 0) begin
					col = pick_coord(ow);
					row = pick_coord(oh);
					prime_window(col, row);
					send_word(KIND_READ, col, row, $urandom, 1'b0, '0);
				end else if (pick < 72 && nw > 0 && nh > 0) begin
					send_word(KIND_WRITE, $urandom_range(0, nw - 1), $urandom_range(0, nh - 1),
						random_coef(), 1'b0, '0);
				end else if (pick < 82) begin
					send_word(KIND_WRITE, $urandom_range(0, SIDE - 1),
						$urandom_range(0, SIDE - 1), random_coef(), 1'b0, '0);
				end else if (pick < 90) begin
					// Beyond the storage: the block drops these.
					col = $urandom_range(0, 511);
					row = $urandom_range(SIDE, 511);
					if ($urandom_range(1)) begin
						send_word(KIND_WRITE, row, col, $urandom, 1'b0, '0);
					end else begin
						send_word(KIND_WRITE, col, row, $urandom, 1'b0, '0);
					end
				end else begin
					col = $urandom_range(0, 511);
					row = $urandom_range(0, 511);
					prime_window(col, row);
					send_word(KIND_READ, col, row, $urandom, 1'b0, '0);
				end
			end
		end

		settle();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
